FILE: rtl/assert_macros.svh
// Assertion macros used by the swept circle hit test RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SCHT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Same check, reporting a message that names the failing condition.
`define SCHT_ASSERT_MSG(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

`endif

FILE: rtl/scht_pkg.sv
// Types, constants and the rotation angle table of the swept circle hit test.
package scht_pkg;

   localparam int MaxSubsteps = 16;
   localparam int CordIters   = 14;
   localparam int PW  = 20;
   localparam int MW  = 22;
   localparam int PRW = 2 * MW;
   localparam int CW  = 18;
   localparam int ZW  = 16;

   typedef struct packed {
      logic               bullet_active;
      logic signed [15:0] bullet_x;
      logic signed [15:0] bullet_y;
      logic [11:0]        bullet_radius;
      logic [11:0]        bullet_speed;
      logic [15:0]        bullet_heading;
      logic [7:0]         bullet_index;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic [11:0]        target_radius;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] hit_index;
   } rsp_type;

   function automatic logic signed [ZW-1:0] cordic_angle(input logic [3:0] i);
      logic signed [ZW-1:0] a;
      case (i)
         4'd0:    a = 16'sd8192;
         4'd1:    a = 16'sd4836;
         4'd2:    a = 16'sd2555;
         4'd3:    a = 16'sd1297;
         4'd4:    a = 16'sd651;
         4'd5:    a = 16'sd326;
         4'd6:    a = 16'sd163;
         4'd7:    a = 16'sd81;
         4'd8:    a = 16'sd41;
         4'd9:    a = 16'sd20;
         4'd10:   a = 16'sd10;
         4'd11:   a = 16'sd5;
         4'd12:   a = 16'sd3;
         4'd13:   a = 16'sd1;
         default: a = 16'sd0;
      endcase
      return a;
   endfunction

endpackage

FILE: rtl/swept_circle_hit_test.sv
// Swept circle hit test of one projectile against one target circle.
// A request carries one projectile and one target; each request yields exactly
// one response with the hit flag and the echoed projectile slot number.
// The block takes one request at a time: req_stall is high from acceptance
// until the response has been taken. All products go through one shared
// 22 x 22 multiplier, and the heading rotation runs one step per cycle.
// An inactive projectile or a zero radius sum goes straight to the response;
// when speed does not exceed the radius only the projectile position is
// tested, and a fast projectile is tested at N sample points (N from 3 to
// 17) until a hit, which ends the test early. Each tested point goes through
// two squares in the multiplier and one compare. The next request can be
// taken in the cycle after the response has been taken.
// Reset is synchronous and active high; it returns the sequencer to idle and
// drops rsp_valid. While rsp_stall is high the response holds unchanged and
// no new request is taken.
`include "assert_macros.svh"
module swept_circle_hit_test
   import scht_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RR    = 9'b000000010,
      ST_RRW   = 9'b000000100,
      ST_CORD  = 9'b000001000,
      ST_SCALE = 9'b000010000,
      ST_TX    = 9'b000100000,
      ST_TY    = 9'b001000000,
      ST_TC    = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [12:0] r_ff, r_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [3:0] it_ff, it_in;
   logic [1:0] q_ff, q_in;
   logic [2:0] sc_ff, sc_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in, stx_ff, stx_in, sty_ff, sty_in;
   logic [4:0] k_ff, k_in;
   logic [17:0] acc_ff, acc_in;
   logic last_ff, last_in, hit_ff, hit_in;
   logic signed [PRW-1:0] prod_ff, sq_ff, sq_in, rr_ff, rr_in;
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [CW-1:0] xs, ys, c_val, s_val;
   logic signed [PRW-1:0] rnd;
   logic signed [PW-1:0] off;
   logic signed [PW:0] dx, dy;
   logic signed [PRW:0] dist_sq;
   logic [15:0] t_val;
   logic [17:0] acc_nx;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = '{hit: hit_ff, hit_index: req_ff.bullet_index};

   always_comb begin
      xs = x_ff >>> it_ff;
      ys = y_ff >>> it_ff;
      case (q_ff)
         2'd0:    begin c_val = x_ff;  s_val = y_ff;  end
         2'd1:    begin c_val = -y_ff; s_val = x_ff;  end
         2'd2:    begin c_val = -x_ff; s_val = -y_ff; end
         default: begin c_val = y_ff;  s_val = -x_ff; end
      endcase
      rnd  = (prod_ff + PRW'(8192)) >>> 14;
      off  = rnd[PW-1:0];
      dx   = {px_ff[PW-1], px_ff} - (PW+1)'(req_ff.target_x);
      dy   = {py_ff[PW-1], py_ff} - (PW+1)'(req_ff.target_y);
      dist_sq = {sq_ff[PRW-1], sq_ff} + {prod_ff[PRW-1], prod_ff};
      t_val  = req_ff.bullet_heading + 16'd8192;
      acc_nx = acc_ff + 18'(r_ff);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RR: begin
            mul_a = MW'(r_ff);
            mul_b = MW'(r_ff);
         end
         ST_SCALE: begin
            mul_a = sc_ff[1] ? MW'(r_ff) : MW'(req_ff.bullet_speed);
            mul_b = sc_ff[0] ? MW'(s_val) : MW'(c_val);
         end
         ST_TX: begin
            mul_a = MW'(dx);
            mul_b = MW'(dx);
         end
         ST_TY: begin
            mul_a = MW'(dy);
            mul_b = MW'(dy);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      r_in = r_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      it_in = it_ff;
      q_in = q_ff;
      sc_in = sc_ff;
      px_in = px_ff;
      py_in = py_ff;
      stx_in = stx_ff;
      sty_in = sty_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      last_in = last_ff;
      hit_in = hit_ff;
      sq_in = sq_ff;
      rr_in = rr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               r_in = 13'(req_data.bullet_radius) + 13'(req_data.target_radius);
               hit_in = 1'b0;
               if (!req_data.bullet_active || r_in == 13'd0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RR;
               end
            end
         end
         ST_RR: begin
            state_in = ST_RRW;
         end
         ST_RRW: begin
            rr_in = prod_ff;
            k_in = '0;
            acc_in = '0;
            if (13'(req_ff.bullet_speed) > r_ff) begin
               x_in = CW'(9949);
               y_in = '0;
               q_in = t_val[15:14];
               z_in = $signed({2'b00, t_val[13:0]}) - 16'sd8192;
               it_in = '0;
               last_in = 1'b0;
               state_in = ST_CORD;
            end else begin
               px_in = PW'(req_ff.bullet_x);
               py_in = PW'(req_ff.bullet_y);
               last_in = 1'b1;
               state_in = ST_TX;
            end
         end
         ST_CORD: begin
            if (!z_ff[ZW-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - cordic_angle(it_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + cordic_angle(it_ff);
            end
            it_in = it_ff + 4'd1;
            sc_in = '0;
            if (it_ff == 4'(CordIters - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            sc_in = sc_ff + 3'd1;
            case (sc_ff)
               3'd1: px_in = PW'(req_ff.bullet_x) - off;
               3'd2: py_in = PW'(req_ff.bullet_y) - off;
               3'd3: stx_in = off;
               3'd4: begin
                  sty_in = off;
                  state_in = ST_TX;
               end
               default: ;
            endcase
         end
         ST_TX: begin
            state_in = ST_TY;
         end
         ST_TY: begin
            sq_in = prod_ff;
            state_in = ST_TC;
         end
         ST_TC: begin
            if (dist_sq < {rr_ff[PRW-1], rr_ff}) begin
               hit_in = 1'b1;
               state_in = ST_OUT;
            end else if (last_ff) begin
               state_in = ST_OUT;
            end else if (k_ff < 5'(MaxSubsteps - 1) && acc_nx < 18'(req_ff.bullet_speed)) begin
               px_in = px_ff + stx_ff;
               py_in = py_ff + sty_ff;
               k_in = k_ff + 5'd1;
               acc_in = acc_nx;
               state_in = ST_TX;
            end else begin
               px_in = PW'(req_ff.bullet_x);
               py_in = PW'(req_ff.bullet_y);
               last_in = 1'b1;
               state_in = ST_TX;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff <= req_in;
      r_ff <= r_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      it_ff <= it_in;
      q_ff <= q_in;
      sc_ff <= sc_in;
      px_ff <= px_in;
      py_ff <= py_in;
      stx_ff <= stx_in;
      sty_ff <= sty_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      last_ff <= last_in;
      hit_ff <= hit_in;
      sq_ff <= sq_in;
      rr_ff <= rr_in;
      prod_ff <= mul_a * mul_b;
   end

   `SCHT_ASSERT(a_tc_after_ty, (state_ff == ST_TC) |-> ($past(state_ff) == ST_TY))
   `SCHT_ASSERT(a_k_capped, (state_ff == ST_TC) |-> (k_ff < 5'(MaxSubsteps)))
   `SCHT_ASSERT_MSG(a_hit_active, (rsp_valid && rsp_data.hit) |-> req_ff.bullet_active, "hit reported for an inactive projectile")

endmodule
